@@ src/ptsc_pkg.sv @@
// Shared types and constants for the pattern trigger sample capture block.
// No dependencies; imported by the capture core and its checker.
`timescale 1ns / 1ps
`default_nettype none

package ptsc_pkg;

  // Number of samples taken per capture
  localparam int unsigned DEPTH = 32768;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  localparam int unsigned PIN_W     = 8;
  localparam int unsigned PERIOD_W  = 17;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned SIDX_W    = 15;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned APB_W     = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(5);
  localparam logic [FRAME_W-1:0]  TIMEOUT_RESET = FRAME_W'(50 * 5);

  // Register word indexes (byte address / 4)
  localparam logic [1:0] REG_PATTERN = 2'd0;
  localparam logic [1:0] REG_MASK    = 2'd1;
  localparam logic [1:0] REG_PERIOD  = 2'd2;
  localparam logic [1:0] REG_TIMEOUT = 2'd3;

  // Input item kinds carried on s_tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ARM  = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT_WHILE,
    PH_WAIT_UNTIL,
    PH_CAPTURE
  } phase_t;

endpackage

`default_nettype wire

@@ src/pattern_trigger_sample_capture.sv @@
// Pattern trigger and sample capture core with its APB register file.
// Depends on ptsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Logic analyzer trigger and capture. Each input item is either a timer tick
// carrying the eight probe pins (s_tuser = 0) or an arm command (s_tuser = 1).
// After arming, a nonzero trigger_mask makes the block wait while the masked
// pins equal the masked pattern, then until they equal it again; a zero mask
// starts at once, and timeout_frames frame ticks (s_tlast) force the start.
// A capture emits DEPTH samples, the first on the second tick after the start
// and then one every sample_period ticks. The block takes one item every clock:
// each item is decided combinationally from the state registers and any
// sample goes to an output register, so s_tready stays high unless that
// register holds a sample the downstream side has not taken. Register writes
// act on the next item: a new pattern or mask is used at once while waiting,
// and a new sample_period applies at the next reload during a capture.
module pattern_trigger_sample_capture
  import ptsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // APB register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [APB_W-1:0]      pwdata,
  output      logic [APB_W-1:0]      prdata,
  output      logic                  pready,
  // input stream
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [PIN_W-1:0]      s_tdata,   // [7:0] pins
  input  wire logic                  s_tuser,   // cmd
  input  wire logic                  s_tlast,   // frame_tick
  // output stream
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [OUT_DATA_W-1:0] m_tdata,   // [14:0] sample_index, [22:15] sample_data
  output      logic                  m_tuser,   // forced_by_timeout
  output      logic                  m_tlast    // last_sample
);

  // register file
  logic [PIN_W-1:0]    trigger_pattern;
  logic [PIN_W-1:0]    trigger_mask;
  logic [PERIOD_W-1:0] sample_period;
  logic [FRAME_W-1:0]  timeout_frames;
  logic                cfg_we;
  logic [1:0]          reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_pattern <= '0;
      trigger_mask    <= '0;
      sample_period   <= PERIOD_RESET;
      timeout_frames  <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_PATTERN: trigger_pattern <= pwdata[PIN_W-1:0];
        REG_MASK:    trigger_mask    <= pwdata[PIN_W-1:0];
        REG_PERIOD:  sample_period   <= pwdata[PERIOD_W-1:0];
        REG_TIMEOUT: timeout_frames  <= pwdata[FRAME_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN: prdata = APB_W'(trigger_pattern);
      REG_MASK:    prdata = APB_W'(trigger_mask);
      REG_PERIOD:  prdata = APB_W'(sample_period);
      REG_TIMEOUT: prdata = APB_W'(timeout_frames);
      default:     prdata = '0;
    endcase
  end

  // capture state
  phase_t              phase, phase_next;
  logic [FRAME_W-1:0]  frame_count, frame_count_next;
  logic [PERIOD_W-1:0] period_count, period_count_next;
  logic [IDX_W-1:0]    write_index, write_index_next;
  logic                timed_out, timed_out_next;

  logic                s_fire;
  logic                match;
  logic [FRAME_W-1:0]  frame_inc;
  logic                emit;
  logic                m_tvalid_next;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign match    = (s_tdata & trigger_mask) == (trigger_pattern & trigger_mask);
  assign frame_inc = frame_count + FRAME_W'(s_tlast);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      frame_count  <= '0;
      period_count <= '0;
      write_index  <= '0;
      timed_out    <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      phase        <= phase_next;
      frame_count  <= frame_count_next;
      period_count <= period_count_next;
      write_index  <= write_index_next;
      timed_out    <= timed_out_next;
      m_tvalid     <= m_tvalid_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    frame_count_next  = frame_count;
    period_count_next = period_count;
    write_index_next  = write_index;
    timed_out_next    = timed_out;
    emit              = 1'b0;

    if (s_fire) begin
      if (s_tuser == CMD_ARM) begin
        frame_count_next  = '0;
        write_index_next  = '0;
        if (trigger_mask == '0 || timeout_frames == '0) begin
          phase_next        = PH_CAPTURE;
          period_count_next = PERIOD_W'(2);
          timed_out_next    = (trigger_mask != '0);
        end else begin
          phase_next        = PH_WAIT_WHILE;
          period_count_next = '0;
          timed_out_next    = 1'b0;
        end
      end else begin
        unique case (phase) inside
          PH_WAIT_WHILE, PH_WAIT_UNTIL: begin
            frame_count_next = frame_inc;
            // timeout wins over the pin test on the same tick
            if (frame_inc == timeout_frames) begin
              phase_next        = PH_CAPTURE;
              period_count_next = PERIOD_W'(2);
              write_index_next  = '0;
              timed_out_next    = 1'b1;
            end else if (phase == PH_WAIT_WHILE) begin
              if (!match) phase_next = PH_WAIT_UNTIL;
            end else if (match) begin
              phase_next        = PH_CAPTURE;
              period_count_next = PERIOD_W'(2);
              write_index_next  = '0;
              timed_out_next    = 1'b0;
            end
          end
          PH_CAPTURE: begin
            if (period_count > PERIOD_W'(1)) begin
              period_count_next = period_count - PERIOD_W'(1);
            end else begin
              emit              = 1'b1;
              period_count_next = sample_period;
              if (write_index == IDX_W'(DEPTH - 1)) begin
                phase_next        = PH_IDLE;
                write_index_next  = '0;
                period_count_next = '0;
              end else begin
                write_index_next = write_index + IDX_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (emit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  // output register: load only on a new sample
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {1'b0, s_tdata, SIDX_W'(write_index)};
      m_tlast <= (write_index == IDX_W'(DEPTH - 1));
      m_tuser <= timed_out;
    end
  end

endmodule

`default_nettype wire

@@ src/ptsc_checker.sv @@
// Port-level checker for pattern_trigger_sample_capture, bound into that module.
// Depends on ptsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ptsc_checker
  import ptsc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic                  m_tuser,
  input wire logic                  m_tlast
);

  // a stalled sample holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output sample changed while stalled");

  // input side only stalls behind a waiting sample
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  // last sample carries the final index
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[SIDX_W-1:0] == SIDX_W'(DEPTH - 1))
    else $error("last sample flag on wrong index");

  // a new sample follows an accepted tick item
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == CMD_TICK))
    else $error("sample without an accepted tick item");

endmodule

bind pattern_trigger_sample_capture ptsc_checker u_ptsc_checker (.*);

`default_nettype wire

@@ tb/sv/tb_pattern_trigger_sample_capture.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pattern_trigger_sample_capture: stream items in, samples out,
// each sample compared with an in-bench prediction. Depends on ptsc_pkg and the block.

module tb_pattern_trigger_sample_capture;
  import ptsc_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS  = 1400;
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef struct packed {
    logic             cmd;
    logic [PIN_W-1:0] pins;
    logic             frame_tick;
  } probe_item_t;

  typedef struct packed {
    logic [SIDX_W-1:0] index;
    logic [PIN_W-1:0]  data;
    logic              last;
    logic              forced;
  } capture_sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [APB_W-1:0]  pwdata  = '0;
  logic [APB_W-1:0]  prdata;
  logic              pready;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIN_W-1:0]      s_tdata  = '0;       // [7:0] pins
  logic                  s_tuser  = CMD_TICK; // cmd
  logic                  s_tlast  = 1'b0;     // frame_tick
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;             // [14:0] sample_index, [22:15] sample_data
  logic                  m_tuser;             // forced_by_timeout
  logic                  m_tlast;             // last_sample

  // predicted block state and register copies
  logic [PIN_W-1:0]    cfg_pattern = '0;
  logic [PIN_W-1:0]    cfg_mask    = '0;
  logic [PERIOD_W-1:0] cfg_period  = PERIOD_RESET;
  logic [FRAME_W-1:0]  cfg_timeout = TIMEOUT_RESET;
  phase_t              cap_phase   = PH_IDLE;
  logic [FRAME_W-1:0]  frame_cnt   = '0;
  logic [PERIOD_W-1:0] period_cnt  = '0;
  int unsigned         wr_idx      = 0;
  logic                timed_out   = 1'b0;

  probe_item_t     pending_items[$];
  capture_sample_t expected_samples[$];

  int unsigned items_queued    = 0;
  int unsigned items_accepted  = 0;
  int unsigned samples_checked = 0;
  int unsigned forced_samples  = 0;
  int unsigned last_samples    = 0;
  int unsigned mismatch_count  = 0;
  int unsigned idle_cycles     = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned send_gap        = 0;
  int unsigned recv_gap        = 0;
  int unsigned send_quiet      = 0;
  int unsigned recv_quiet      = 0;
  int unsigned random_start;

  pattern_trigger_sample_capture i_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Mostly back to back, some short gaps, a few long ones, and now and then a quiet stretch.
  function automatic int unsigned next_gap(inout int unsigned quiet);
    int unsigned r;
    r = $urandom_range(0, 199);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if (r == 0) begin
      quiet = $urandom_range(50, 300);
      return 0;
    end
    if (r < 120) return 0;
    if (r < 185) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void begin_capture(input logic forced);
    cap_phase  = PH_CAPTURE;
    period_cnt = PERIOD_W'(2);
    wr_idx     = 0;
    timed_out  = forced;
  endfunction

  // Advance the predicted state by one item; returns 1 when the item yields a sample.
  function automatic bit predict_sample(input probe_item_t it, output capture_sample_t smp);
    logic hit;
    hit = ((it.pins ^ cfg_pattern) & cfg_mask) == '0;
    smp = '0;
    if (it.cmd == CMD_ARM) begin
      frame_cnt = '0;
      if (cfg_mask == '0) begin
        begin_capture(1'b0);
      end else if (cfg_timeout == '0) begin
        begin_capture(1'b1);
      end else begin
        cap_phase  = PH_WAIT_WHILE;
        period_cnt = '0;
        wr_idx     = 0;
        timed_out  = 1'b0;
      end
      return 1'b0;
    end
    case (cap_phase) inside
      PH_WAIT_WHILE, PH_WAIT_UNTIL: begin
        if (it.frame_tick) frame_cnt = frame_cnt + 1'b1;
        // timeout wins over the pin test on the same tick
        if (frame_cnt == cfg_timeout) begin
          begin_capture(1'b1);
        end else if (cap_phase == PH_WAIT_WHILE) begin
          if (!hit) cap_phase = PH_WAIT_UNTIL;
        end else if (hit) begin
          begin_capture(1'b0);
        end
        return 1'b0;
      end
      PH_CAPTURE: begin
        if (period_cnt > 1) begin
          period_cnt = period_cnt - 1'b1;
          return 1'b0;
        end
        period_cnt = cfg_period;
        smp.index  = SIDX_W'(wr_idx);
        smp.data   = it.pins;
        smp.last   = (wr_idx == DEPTH - 1);
        smp.forced = timed_out;
        if (wr_idx >= DEPTH - 1) begin
          cap_phase  = PH_IDLE;
          wr_idx     = 0;
          period_cnt = '0;
        end else begin
          wr_idx++;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at sample %0d: %s", samples_checked, what);
    mismatch_count++;
  endtask

  task automatic push_item(input logic cmd, input logic [PIN_W-1:0] pins, input logic ft);
    pending_items.push_back(probe_item_t'{cmd, pins, ft});
    items_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [APB_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PATTERN: cfg_pattern = value[PIN_W-1:0];
      REG_MASK:    cfg_mask    = value[PIN_W-1:0];
      REG_PERIOD:  cfg_period  = value[PERIOD_W-1:0];
      REG_TIMEOUT: cfg_timeout = value[FRAME_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Hold until every item is taken and every sample checked, then let the block settle.
  task automatic drain();
    @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_samples.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic frame_roll();
    return $urandom_range(0, 5) == 0;
  endfunction

  function automatic logic [PIN_W-1:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PIN_W'($urandom);
  endfunction

  function automatic logic [PIN_W-1:0] matching_pins();
    return (cfg_pattern & cfg_mask) | (PIN_W'($urandom) & ~cfg_mask);
  endfunction

  function automatic logic [PIN_W-1:0] missing_pins();
    int unsigned b;
    if (cfg_mask == '0) return PIN_W'($urandom);
    do b = $urandom_range(0, PIN_W - 1); while (!cfg_mask[b]);
    return matching_pins() ^ (PIN_W'(1) << b);
  endfunction

  task automatic random_config();
    int unsigned         roll;
    logic [PERIOD_W-1:0] period;
    logic [FRAME_W-1:0]  timeout;
    roll = $urandom_range(0, 19);
    if (roll == 0) period = PERIOD_W'(65536);
    else if (roll < 3) period = PERIOD_W'(2);
    else if (roll < 5) period = PERIOD_W'($urandom_range(9, 300));
    else period = PERIOD_W'($urandom_range(2, 8));
    roll = $urandom_range(0, 19);
    if (roll < 2) timeout = '1;
    else if (roll < 6) timeout = FRAME_W'($urandom_range(20, 2000));
    else timeout = FRAME_W'($urandom_range(1, 6));
    write_reg(REG_PATTERN, APB_W'(pick_byte()));
    write_reg(REG_MASK, ($urandom_range(0, 5) == 0) ? APB_W'(0) : APB_W'(pick_byte()));
    write_reg(REG_PERIOD, APB_W'(period));
    write_reg(REG_TIMEOUT, APB_W'(timeout));
  endtask

  // Mostly well-formed trigger runs: arm, hold on the pattern, leave it, return to it,
  // then let the capture run; the rest is random noise with stray arms.
  task automatic random_phase();
    int unsigned runs;
    runs = $urandom_range(3, 6);
    repeat (runs) begin
      if ($urandom_range(0, 9) < 8) begin
        push_item(CMD_ARM, PIN_W'($urandom), 1'($urandom));
        repeat ($urandom_range(0, 4)) push_item(CMD_TICK, matching_pins(), frame_roll());
        repeat ($urandom_range(1, 5)) push_item(CMD_TICK, missing_pins(), frame_roll());
        push_item(CMD_TICK, matching_pins(), frame_roll());
        repeat ($urandom_range(4, 40)) push_item(CMD_TICK, PIN_W'($urandom), frame_roll());
      end else begin
        repeat ($urandom_range(5, 15))
          push_item(($urandom_range(0, 7) == 0) ? CMD_ARM : CMD_TICK, PIN_W'($urandom),
                    frame_roll());
      end
    end
  endtask

  // input driver
  always @(posedge clk) begin
    probe_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= nxt.cmd;
        s_tdata  <= nxt.pins;
        s_tlast  <= nxt.frame_tick;
        send_gap <= next_gap(send_quiet);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // prediction on every accepted item
  always @(posedge clk) begin
    capture_sample_t predicted;
    if (!rst && s_tvalid && s_tready) begin
      items_accepted++;
      if (predict_sample(probe_item_t'{s_tuser, s_tdata, s_tlast}, predicted))
        expected_samples.push_back(predicted);
    end
  end

  // output ready: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      m_tready        <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (recv_gap > 0) begin
      m_tready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if (m_tvalid && m_tready) recv_gap <= next_gap(recv_quiet);
    end
  end

  // sample checker
  always @(posedge clk) begin
    capture_sample_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("sample arrived with nothing expected");
      end else begin
        want = expected_samples.pop_front();
        if (m_tdata[SIDX_W-1:0] !== want.index)
          report_mismatch($sformatf("sample_index %0d, want %0d",
                                    m_tdata[SIDX_W-1:0], want.index));
        if (m_tdata[SIDX_W+PIN_W-1:SIDX_W] !== want.data)
          report_mismatch($sformatf("sample_data %02h, want %02h",
                                    m_tdata[SIDX_W+PIN_W-1:SIDX_W], want.data));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last_sample %b, want %b", m_tlast, want.last));
        if (m_tuser !== want.forced)
          report_mismatch($sformatf("forced_by_timeout %b, want %b", m_tuser, want.forced));
        if (want.forced) forced_samples++;
        if (want.last) last_samples++;
      end
      samples_checked++;
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset registers: zero mask, so the arm starts capture at once
    push_item(CMD_TICK, 8'h00, 1'b1);
    push_item(CMD_ARM, 8'hFF, 1'b1);
    push_item(CMD_TICK, 8'h3C, 1'b1);
    push_item(CMD_TICK, 8'hFF, 1'b1);
    push_item(CMD_TICK, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h81, 1'b1);
    drain();

    // full mask: timeout lands on a matching tick, then re-arm mid-capture
    write_reg(REG_PATTERN, 32'hA5);
    write_reg(REG_MASK, 32'hFF);
    write_reg(REG_PERIOD, 32'd1);
    write_reg(REG_TIMEOUT, 32'd2);
    push_item(CMD_ARM, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'hA5, 1'b0);
    push_item(CMD_TICK, 8'h5A, 1'b1);
    push_item(CMD_TICK, 8'hA5, 1'b1);
    push_item(CMD_TICK, 8'h11, 1'b0);
    push_item(CMD_TICK, 8'hEE, 1'b0);
    push_item(CMD_ARM, 8'hA5, 1'b0);
    push_item(CMD_TICK, 8'h5A, 1'b0);
    push_item(CMD_TICK, 8'hA5, 1'b0);
    push_item(CMD_TICK, 8'h01, 1'b1);
    push_item(CMD_TICK, 8'hFE, 1'b0);
    drain();

    // zero timeout forces the start at the arm; zero period samples every tick
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_PERIOD, 32'd0);
    push_item(CMD_ARM, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h42, 1'b0);
    push_item(CMD_TICK, 8'h24, 1'b0);
    push_item(CMD_TICK, 8'hC3, 1'b0);
    drain();

    // pattern rewritten while waiting, period rewritten while capturing
    write_reg(REG_TIMEOUT, 32'hFFFF);
    write_reg(REG_MASK, 32'h0F);
    write_reg(REG_PATTERN, 32'h03);
    push_item(CMD_ARM, 8'h00, 1'b0);
    push_item(CMD_TICK, 8'h13, 1'b0);
    drain();
    write_reg(REG_PATTERN, 32'h05);
    push_item(CMD_TICK, 8'h13, 1'b0);
    push_item(CMD_TICK, 8'h25, 1'b0);
    push_item(CMD_TICK, 8'h77, 1'b0);
    drain();
    write_reg(REG_PERIOD, 32'h10000);
    push_item(CMD_TICK, 8'h99, 1'b0);
    push_item(CMD_TICK, 8'h66, 1'b0);
    drain();

    // back-pressure: output held off while a fast capture keeps offering items
    write_reg(REG_MASK, 32'h00);
    write_reg(REG_PERIOD, 32'd2);
    hold_off_cycles = HOLD_CYCLES;
    push_item(CMD_ARM, 8'h00, 1'b0);
    repeat (150) push_item(CMD_TICK, PIN_W'($urandom), 1'($urandom));
    drain();

    random_start = items_queued;
    while (items_queued - random_start < RANDOM_ITEMS) begin
      random_config();
      random_phase();
      drain();
    end

    $display("covered %0d items in, %0d samples checked, %0d from timeout starts, %0d capture ends",
             items_accepted, samples_checked, forced_samples, last_samples);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/ptsc_pkg.sv
src/pattern_trigger_sample_capture.sv
src/ptsc_checker.sv
tb/sv/tb_pattern_trigger_sample_capture.sv
